[hw/rtl/wdm_pkg.sv]
`timescale 1ns / 1ps

package wdm_pkg;

  // fixed field widths
  localparam int CMD_W     = 2;
  localparam int LEN_W     = 4;
  localparam int LETTER_W  = 5;
  localparam int LETTERS_W = 60;
  localparam int INDEX_W   = 6;
  localparam int STATUS_W  = 2;

  // highest letter code
  localparam logic [LETTER_W-1:0] CODE_MAX = LETTER_W'(26);
  localparam logic [LETTER_W-1:0] CODE_WILD = '0;

  // defaults for the top level parameters
  localparam int MAX_LETTERS_DEF = 12;
  localparam int TABLE_DEPTH_DEF = 64;

  // queue depths
  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int RES_QUEUE_DEPTH = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_CODE = 2'd2,
    ST_BAD_LEN  = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_SCAN = 1'b1
  } back_state_t;

  // classified item, less its letters
  typedef struct packed {
    cmd_t               op;
    status_t            status;
    logic [LEN_W-1:0]   len;
  } desc_ctrl_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] index;
    logic               last;
    status_t            status;
  } result_t;

endpackage

[hw/rtl/wdm_queue.sv]
`timescale 1ns / 1ps

module wdm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

[hw/rtl/wdm_front.sv]
`timescale 1ns / 1ps

module wdm_front #(
  parameter int MAX_LETTERS = wdm_pkg::MAX_LETTERS_DEF
) (
  input  logic                              push,
  output logic                              full,
  input  logic [wdm_pkg::CMD_W-1:0]         cmd,
  input  logic [wdm_pkg::LEN_W-1:0]         word_length,
  input  logic [wdm_pkg::LETTERS_W-1:0]     letters,
  input  logic                              q_full,
  output logic                              q_push,
  output wdm_pkg::desc_ctrl_t               q_ctrl,
  output logic [MAX_LETTERS*wdm_pkg::LETTER_W-1:0] q_letters
);

  import wdm_pkg::*;

  localparam int LW = MAX_LETTERS * LETTER_W;

  logic          is_load;
  logic          known_cmd;
  logic          bad_len;
  logic          bad_code;
  logic [LW-1:0] masked;

  assign is_load   = (cmd == CMD_LOAD);
  assign known_cmd = (cmd == CMD_LOAD) || (cmd == CMD_QUERY) || (cmd == CMD_CLEAR);
  assign bad_len   = (word_length == '0) || (word_length > LEN_W'(MAX_LETTERS));

  // per-letter checks, positions past the length are dropped
  always_comb begin
    logic [LETTER_W-1:0] code;
    logic                live;
    bad_code = 1'b0;
    masked   = '0;
    for (int p = 0; p < MAX_LETTERS; p++) begin
      code = letters[p*LETTER_W +: LETTER_W];
      live = (LEN_W'(p) < word_length);
      if (live) begin
        masked[p*LETTER_W +: LETTER_W] = code;
        if ((code > CODE_MAX) || ((code == CODE_WILD) && is_load)) begin
          bad_code = 1'b1;
        end
      end
    end
  end

  always_comb begin
    q_ctrl.op  = cmd_t'(cmd);
    q_ctrl.len = word_length;
    priority if (cmd == CMD_CLEAR) begin
      q_ctrl.status = ST_OK;
    end else if (bad_len) begin
      q_ctrl.status = ST_BAD_LEN;
    end else if (bad_code) begin
      q_ctrl.status = ST_BAD_CODE;
    end else begin
      q_ctrl.status = ST_OK;
    end
  end

  // unused command code is taken and dropped
  assign full      = q_full;
  assign q_push    = push && !q_full && known_cmd;
  assign q_letters = masked;

endmodule

[hw/rtl/wdm_back.sv]
`timescale 1ns / 1ps

module wdm_back #(
  parameter int MAX_LETTERS = wdm_pkg::MAX_LETTERS_DEF,
  parameter int TABLE_DEPTH = wdm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  wdm_pkg::desc_ctrl_t               q_ctrl,
  input  logic [MAX_LETTERS*wdm_pkg::LETTER_W-1:0] q_letters,
  output logic                              q_pop,
  output wdm_pkg::result_t                  res,
  output logic                              empty,
  input  logic                              pop
);

  import wdm_pkg::*;

  localparam int LW = MAX_LETTERS * LETTER_W;
  localparam int MW = LW + LEN_W;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [MW-1:0]    mem [TABLE_DEPTH];
  logic [MW-1:0]    rdata;

  back_state_t      state;
  back_state_t      state_next;
  logic [CW-1:0]    count;
  logic [CW-1:0]    rd_addr;
  logic             cmp_valid;
  logic [AW-1:0]    cmp_idx;
  logic             pend_valid;
  logic [AW-1:0]    pend_idx;
  logic [LW-1:0]    pat;
  logic [LEN_W-1:0] plen;

  logic             o_push;
  logic             o_full;
  result_t          o_data;
  logic             wr_en;
  logic             count_clr;
  logic             scan_start;
  logic             finish;
  logic             match;
  logic             stall;
  logic             issue;
  logic             scan_done;

  // compare the registered word from the table read with the pattern
  always_comb begin
    logic [LETTER_W-1:0] pc;
    match = cmp_valid && (rdata[MW-1 -: LEN_W] == plen);
    for (int p = 0; p < MAX_LETTERS; p++) begin
      pc = pat[p*LETTER_W +: LETTER_W];
      if ((pc != CODE_WILD) && (pc != rdata[p*LETTER_W +: LETTER_W])) begin
        match = 1'b0;
      end
    end
  end

  assign stall     = match && pend_valid && o_full;
  assign issue     = (state == BK_SCAN) && !stall && (rd_addr < count);
  assign scan_done = !cmp_valid && (rd_addr >= count);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (scan_start) state_next = BK_SCAN;
      BK_SCAN: if (finish) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    o_push     = 1'b0;
    o_data     = '{found: 1'b0, index: '0, last: 1'b1, status: ST_OK};
    wr_en      = 1'b0;
    count_clr  = 1'b0;
    scan_start = 1'b0;
    finish     = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty && !o_full) begin
          q_pop = 1'b1;
          unique case (q_ctrl.op)
            CMD_LOAD: begin
              o_push = 1'b1;
              priority if (q_ctrl.status != ST_OK) begin
                o_data.status = q_ctrl.status;
              end else if (count == CW'(TABLE_DEPTH)) begin
                o_data.status = ST_FULL;
              end else begin
                wr_en        = 1'b1;
                o_data.index = INDEX_W'(count);
              end
            end
            CMD_QUERY: begin
              if (q_ctrl.status != ST_OK) begin
                o_push        = 1'b1;
                o_data.status = q_ctrl.status;
              end else begin
                scan_start = 1'b1;
              end
            end
            CMD_CLEAR: begin
              o_push    = 1'b1;
              count_clr = 1'b1;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      BK_SCAN: begin
        if (match && pend_valid && !stall) begin
          // a newer match shows the held one is not the final one
          o_push       = 1'b1;
          o_data.found = 1'b1;
          o_data.index = INDEX_W'(pend_idx);
          o_data.last  = 1'b0;
        end else if (scan_done && !o_full) begin
          o_push       = 1'b1;
          finish       = 1'b1;
          o_data.found = pend_valid;
          o_data.index = pend_valid ? INDEX_W'(pend_idx) : '0;
        end
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      count      <= '0;
      cmp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (count_clr) begin
        count <= '0;
      end else if (wr_en) begin
        count <= count + 1'b1;
      end
      if (scan_start) begin
        cmp_valid  <= 1'b0;
        pend_valid <= 1'b0;
      end else if ((state == BK_SCAN) && !stall) begin
        cmp_valid <= issue;
        if (match) begin
          pend_valid <= 1'b1;
        end
        if (finish) begin
          pend_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      rd_addr <= '0;
      pat     <= q_letters;
      plen    <= q_ctrl.len;
    end else if (issue) begin
      rd_addr <= rd_addr + 1'b1;
    end
    if (issue) begin
      cmp_idx <= rd_addr[AW-1:0];
    end
    if (match && !stall) begin
      pend_idx <= cmp_idx;
    end
  end

  // word table, one write or one read port use per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= {q_ctrl.len, q_letters};
    end
    if (issue) begin
      rdata <= mem[rd_addr[AW-1:0]];
    end
  end

  wdm_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (o_push),
    .wdata (o_data),
    .full  (o_full),
    .pop   (pop),
    .rdata (res),
    .empty (empty)
  );

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("word count beyond table depth");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (count < CW'(TABLE_DEPTH)) && (state == BK_IDLE))
    else $error("table write without room");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == BK_IDLE) |-> !cmp_valid && !pend_valid)
    else $error("scan state left over in idle");

  a_scan_addr: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SCAN) |-> rd_addr <= count)
    else $error("scan address past stored words");

  a_finish_once: assert property (@(posedge clk) disable iff (rst)
    finish |=> (state == BK_IDLE) && !pend_valid)
    else $error("scan did not close");
`endif

endmodule

[hw/rtl/wildcard_dictionary_matcher_unit.sv]
`timescale 1ns / 1ps

// wildcard dictionary matcher: keeps up to TABLE_DEPTH words of up to
// MAX_LETTERS letters (codes 1..26) and answers pattern queries in which
// code 0 is a wildcard. both sides behave as queues: an item goes in when
// push is high and full is low, a result leaves when pop is high and empty
// is low. a load gives one result carrying the slot written or an error
// status (bad length, then bad letter code, then table full); a clear gives
// one result; cmd 3 is taken and dropped. a query gives one result per
// matching word in load order with last on the final one, or a single
// not-found result. the front checks and masks each item in the cycle it
// arrives and hands it through a two-entry queue to the back. the back
// takes a load, clear or rejected query without a scan; a valid query walks
// the stored words through the single-port word table, one read a cycle
// unless a match meets a full result queue, and holds the back until the
// walk ends and the final result is queued. results wait in a two-entry
// queue, so a slow consumer does not stop the front from taking items
// until the command queue fills too
module wildcard_dictionary_matcher_unit #(
  parameter int MAX_LETTERS = wdm_pkg::MAX_LETTERS_DEF,
  parameter int TABLE_DEPTH = wdm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // item side
  input  logic                          push,
  output logic                          full,
  input  logic [wdm_pkg::CMD_W-1:0]     cmd,
  input  logic [wdm_pkg::LEN_W-1:0]     word_length,
  input  logic [wdm_pkg::LETTERS_W-1:0] letters,
  // result side
  output logic                          empty,
  input  logic                          pop,
  output logic                          found,
  output logic [wdm_pkg::INDEX_W-1:0]   index,
  output logic                          last,
  output logic [wdm_pkg::STATUS_W-1:0]  status
);

  import wdm_pkg::*;

  localparam int LW = MAX_LETTERS * LETTER_W;
  localparam int QW = $bits(desc_ctrl_t) + LW;

  // front to queue
  logic          f_push;
  logic          q_full;
  desc_ctrl_t    f_ctrl;
  logic [LW-1:0] f_letters;

  // queue to back
  logic          q_empty;
  logic          q_pop;
  logic [QW-1:0] q_rdata;
  desc_ctrl_t    b_ctrl;
  logic [LW-1:0] b_letters;

  result_t       res;

  wdm_front #(
    .MAX_LETTERS (MAX_LETTERS)
  ) u_front (
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .word_length (word_length),
    .letters     (letters),
    .q_full      (q_full),
    .q_push      (f_push),
    .q_ctrl      (f_ctrl),
    .q_letters   (f_letters)
  );

  // classified items wait here while the back is busy scanning
  wdm_queue #(
    .WIDTH (QW),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata ({f_ctrl, f_letters}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign b_ctrl    = desc_ctrl_t'(q_rdata[QW-1 -: $bits(desc_ctrl_t)]);
  assign b_letters = q_rdata[LW-1:0];

  wdm_back #(
    .MAX_LETTERS (MAX_LETTERS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_ctrl    (b_ctrl),
    .q_letters (b_letters),
    .q_pop     (q_pop),
    .res       (res),
    .empty     (empty),
    .pop       (pop)
  );

  // oldest result on the ports
  assign found  = res.found;
  assign index  = res.index;
  assign last   = res.last;
  assign status = res.status;

endmodule
